[rtl/core/ssf_pkg.sv]
package ssf_pkg;

	// Command codes carried in the input tuser bit.
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_SHOW = 1'b1;

	// Slot kinds carried in the output tuser field.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	// Fixed bytes of the display protocol.
	localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
	localparam logic [7:0] BYTE_CTRL_CMD = 8'h88;
	localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;

	// Number handling: saturation limit and binary width after clamping.
	localparam int          NUM_W       = 14;
	localparam logic [15:0] MAX_NUMBER  = 16'd9999;
	localparam logic [3:0]  DABBLE_STEPS = 4'd14;

	// Bits per byte before the ack slot, and the last digit byte index.
	localparam logic [3:0] ACK_POS       = 4'd8;
	localparam logic [2:0] LAST_DIGIT_IX = 3'd4;

	localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;

	// One queued command: its code and four BCD digits, thousands on top.
	typedef struct packed {
		logic        cmd;
		logic [15:0] bcd;
	} ssf_entry_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} ssf_qstat_t;

	// Segment pattern for one decimal digit.
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		unique case (digit)
			4'd0: code = 8'h3F;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5B;
			4'd3: code = 8'h4F;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6D;
			4'd6: code = 8'h7D;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7F;
			4'd9: code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

[rtl/core/seven_segment_number_serial_framer_top.sv]
// Serial framer for a four-digit seven-segment display driver.
// The input stream (s_*) takes one command per transaction: s_tuser selects
// initialise (0) or show number (1), s_tdata carries the number.
// The output stream (m_*) gives one bit slot per transaction: m_tuser is the
// slot kind (start, data bit, ack, stop), m_tdata bit 0 the data line level,
// and m_tlast marks the final slot of a command's run.
// An initialise command gives 22 slots, a show command 47 slots; the back
// end emits one slot per cycle while the receiver is ready, and the next
// run goes through the idle state when the queue is empty, or follows
// straight on when a command is already queued.
// The front end converts a number to decimal with one shift-and-add step
// per cycle, hidden behind the previous run; initialise commands skip it.
// A two-entry queue sits between converter and slot sequencer, so input
// transactions are taken while the receiver stalls until the queue fills.
// A stalled receiver holds the current slot; nothing is lost or repeated.
// The user must write the brightness register through cfg_* while idle;
// the block does not enforce it. Reset sets it to 7, empties the queue and
// the output, and no clearing pass follows.
module seven_segment_number_serial_framer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] number
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] data_level, [7:1] zero
	output logic [1:0]  m_tuser,   // [1:0] slot_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	import ssf_pkg::*;

	logic [2:0] bright_q;
	ssf_entry_t push_data;
	ssf_entry_t pop_data;
	ssf_qstat_t qstat;
	logic       push;
	logic       pop;
	logic       level;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {7'd0, level};

	// Brightness register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHTNESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bright_q <= cfg_data;
		end
	end

	ssf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_number (s_tdata),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	ssf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	ssf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.brightness (bright_q),
		.qstat      (qstat),
		.pop_data   (pop_data),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_level  (level),
		.out_last   (m_tlast)
	);

`ifndef SYNTHESIS
	// The queue is never written while full nor read while empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full && !pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("queue read while empty");
	// The end of a run is always a stop slot.
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_STOP)
		else $error("last slot is not a stop");
	// Only data bit slots drive the data line high.
	a_level_data_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_DATA) |-> m_tdata[0] == 1'b0)
		else $error("data level set on a non-data slot");
	// A configuration write lands in the brightness register.
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> bright_q == $past(cfg_data))
		else $error("brightness write lost");
`endif

endmodule

[rtl/core/ssf_front.sv]
module ssf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_cmd,
	input  logic [15:0]        in_number,
	input  ssf_pkg::ssf_qstat_t qstat,
	output logic               push,
	output ssf_pkg::ssf_entry_t push_data
);
	import ssf_pkg::*;

	logic              busy_q;
	logic              cmd_q;
	logic [NUM_W-1:0]  bin_q;
	logic [15:0]       bcd_q;
	logic [3:0]        step_q;
	logic              accept;
	logic [NUM_W-1:0]  clamped;
	logic [15:0]       bcd_adj;

	// A finished command leaves as the next one may come in.
	assign push     = busy_q && (step_q == 4'd0) && !qstat.full;
	assign in_ready = !busy_q || push;
	assign accept   = in_valid && in_ready;

	assign push_data.cmd = cmd_q;
	assign push_data.bcd = bcd_q;

	// Saturate the number so that it fits four decimal digits.
	assign clamped = (in_number > MAX_NUMBER) ? MAX_NUMBER[NUM_W-1:0]
		: in_number[NUM_W-1:0];

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Shift-and-add conversion, one bit of the number per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 4'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= (in_cmd == CMD_SHOW) ? DABBLE_STEPS : 4'd0;
		end else if (push) begin
			busy_q <= 1'b0;
		end else if (busy_q && (step_q != 4'd0)) begin
			step_q <= step_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			bin_q <= clamped;
			bcd_q <= 16'd0;
		end else if (busy_q && (step_q != 4'd0)) begin
			bcd_q <= {bcd_adj[14:0], bin_q[NUM_W-1]};
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
		end
	end

endmodule

[rtl/core/ssf_queue.sv]
module ssf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssf_pkg::ssf_entry_t push_data,
	input  logic                pop,
	output ssf_pkg::ssf_entry_t pop_data,
	output ssf_pkg::ssf_qstat_t qstat
);
	import ssf_pkg::*;

	ssf_entry_t  mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign pop_data    = mem_q[rptr_q];

	// Pointers and fill level of the two-entry queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

[rtl/core/ssf_back.sv]
module ssf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          brightness,
	input  ssf_pkg::ssf_qstat_t qstat,
	input  ssf_pkg::ssf_entry_t pop_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic                out_level,
	output logic                out_last
);
	import ssf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_BYTE  = 4'b0100,
		ST_STOP  = 4'b1000
	} state_t;

	state_t      state_q, state_d;
	logic        cur_cmd_q;
	logic [15:0] cur_bcd_q;
	logic        frame_q, frame_d;
	logic [2:0]  byte_ix_q, byte_ix_d;
	logic [3:0]  bit_q, bit_d;
	logic        load;
	logic        adv;
	logic        emit;
	logic [1:0]  kind;
	logic        level;
	logic        last;
	logic [3:0]  digit;
	logic [7:0]  cur_byte;
	logic        frame_last_byte;

	// The output register takes a new slot whenever it is free or drained.
	assign adv = !out_valid || out_ready;

	// Pick the digit for the current byte, thousands first.
	always_comb begin
		unique case (byte_ix_q)
			3'd1: digit = cur_bcd_q[15:12];
			3'd2: digit = cur_bcd_q[11:8];
			3'd3: digit = cur_bcd_q[7:4];
			default: digit = cur_bcd_q[3:0];
		endcase
	end

	// The byte that is being serialised.
	always_comb begin
		if (cur_cmd_q == CMD_INIT) begin
			cur_byte = frame_q ? (BYTE_CTRL_CMD | {5'd0, brightness}) : BYTE_DATA_CMD;
		end else if (byte_ix_q == 3'd0) begin
			cur_byte = BYTE_ADDR_CMD;
		end else begin
			cur_byte = seg_code(digit);
		end
	end

	assign frame_last_byte = (cur_cmd_q == CMD_INIT) || (byte_ix_q == LAST_DIGIT_IX);

	// Slot sequencer.
	always_comb begin
		state_d   = state_q;
		frame_d   = frame_q;
		byte_ix_d = byte_ix_q;
		bit_d     = bit_q;
		pop       = 1'b0;
		load      = 1'b0;
		emit      = 1'b0;
		kind      = KIND_START;
		level     = 1'b0;
		last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					load    = 1'b1;
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (adv) begin
					emit    = 1'b1;
					kind    = KIND_START;
					bit_d   = 4'd0;
					state_d = ST_BYTE;
				end
			end
			ST_BYTE: begin
				if (adv) begin
					emit = 1'b1;
					if (bit_q == ACK_POS) begin
						kind  = KIND_ACK;
						bit_d = 4'd0;
						if (frame_last_byte) begin
							state_d = ST_STOP;
						end else begin
							byte_ix_d = byte_ix_q + 3'd1;
						end
					end else begin
						kind  = KIND_DATA;
						level = cur_byte[bit_q[2:0]];
						bit_d = bit_q + 4'd1;
					end
				end
			end
			ST_STOP: begin
				if (adv) begin
					emit = 1'b1;
					kind = KIND_STOP;
					last = (cur_cmd_q == CMD_SHOW) || frame_q;
					if ((cur_cmd_q == CMD_INIT) && !frame_q) begin
						frame_d   = 1'b1;
						byte_ix_d = 3'd0;
						state_d   = ST_START;
					end else if (!qstat.empty) begin
						pop     = 1'b1;
						load    = 1'b1;
						state_d = ST_START;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			frame_q   <= 1'b0;
			byte_ix_q <= 3'd0;
			bit_q     <= 4'd0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			if (load) begin
				frame_q   <= 1'b0;
				byte_ix_q <= 3'd0;
			end else begin
				frame_q   <= frame_d;
				byte_ix_q <= byte_ix_d;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Command payload and output slot payload.
	always_ff @(posedge clk) begin
		if (load) begin
			cur_cmd_q <= pop_data.cmd;
			cur_bcd_q <= pop_data.bcd;
		end
		if (emit) begin
			out_kind  <= kind;
			out_level <= level;
			out_last  <= last;
		end
	end

endmodule

[verif/ssf_slot_checker.sv]
`timescale 1ns / 100ps

// Watches the command, slot and brightness channels of the display framer,
// works out the slot run that each accepted command must produce and compares
// every slot transaction with the oldest slot still outstanding.
module ssf_slot_checker
	import ssf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	// One serial bit slot as the display link sees it.
	typedef struct packed {
		logic [1:0] kind;
		logic       level;
		logic       last;
	} slot_t;

	// Segment patterns of the decimal digits, zero first.
	localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	slot_t      expected_slots [$];
	logic [2:0] brightness_copy = BRIGHTNESS_RESET;
	int         failures = 0;

	task automatic queue_slot(input logic [1:0] kind, input logic level, input logic last);
		slot_t s;
		s.kind  = kind;
		s.level = level;
		s.last  = last;
		expected_slots.push_back(s);
	endtask

	// A byte goes out least significant bit first and is closed by an ack slot.
	task automatic queue_byte(input logic [7:0] value);
		for (int i = 0; i < 8; i++) begin
			queue_slot(KIND_DATA, value[i], 1'b0);
		end
		queue_slot(KIND_ACK, 1'b0, 1'b0);
	endtask

	// Expands one command into the full run of slots it must give.
	task automatic predict_command_slots(input logic cmd, input logic [15:0] number);
		int value;
		logic [3:0] digits [4];
		value = (number > MAX_NUMBER) ? int'(MAX_NUMBER) : int'(number);
		digits[0] = 4'((value / 1000) % 10);
		digits[1] = 4'((value / 100) % 10);
		digits[2] = 4'((value / 10) % 10);
		digits[3] = 4'(value % 10);
		queue_slot(KIND_START, 1'b0, 1'b0);
		if (cmd == CMD_INIT) begin
			// The first frame's stop is not the end of the run.
			queue_byte(BYTE_DATA_CMD);
			queue_slot(KIND_STOP, 1'b0, 1'b0);
			queue_slot(KIND_START, 1'b0, 1'b0);
			queue_byte(BYTE_CTRL_CMD | {5'b0, brightness_copy});
		end else begin
			queue_byte(BYTE_ADDR_CMD);
			for (int k = 0; k < 4; k++) begin
				queue_byte(DIGIT_SEGMENTS[digits[k]]);
			end
		end
		queue_slot(KIND_STOP, 1'b0, 1'b1);
	endtask

	// Brightness writes, command transactions and slot transactions, in that order.
	always @(posedge clk or negedge arst_n) begin
		slot_t want;
		if (!arst_n) begin
			expected_slots.delete();
			brightness_copy = BRIGHTNESS_RESET;
			fail_count <= failures;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				brightness_copy = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				predict_command_slots(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (expected_slots.size() == 0) begin
					$error("slot_kind: no slot outstanding, got kind %0d level %0b last %0b",
						m_tuser, m_tdata[0], m_tlast);
					failures++;
				end else begin
					want = expected_slots.pop_front();
					if (m_tuser !== want.kind) begin
						$error("slot_kind mismatch: expected %0d, got %0d", want.kind, m_tuser);
						failures++;
					end
					if (m_tdata[0] !== want.level) begin
						$error("data_level mismatch: expected %0b, got %0b", want.level,
							m_tdata[0]);
						failures++;
					end
					if (m_tlast !== want.last) begin
						$error("last mismatch: expected %0b, got %0b", want.last, m_tlast);
						failures++;
					end
				end
			end
			fail_count <= failures;
			pending <= expected_slots.size();
		end
	end

endmodule

[verif/seven_segment_number_serial_framer_top_tb.sv]
`timescale 1ns / 100ps

// Drives display commands and brightness writes into the framer, stalls the
// slot receiver and gives the verdict from the checker's failure count.
module seven_segment_number_serial_framer_top_tb;
	import ssf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 60;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 42;

	// Ways in which the slot receiver holds off.
	typedef enum int {RX_OPEN, RX_COIN, RX_HOLD, RX_PERIODIC} rx_mode_e;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;

	int fail_count;
	int pending;
	int burst_left = 0;
	int tx_gap_max = 6;
	int quiet_cycles = 0;

	rx_mode_e rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_hold_left = 0;
	int       rx_phase = 0;

	seven_segment_number_serial_framer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ssf_slot_checker slot_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver switches between open, coin-toss, long-hold and periodic stalls.
	always @(posedge clk) begin
		logic ready;
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(20, 200);
		end
		rx_mode_left--;
		rx_phase = (rx_phase + 1) % 5;
		case (rx_mode)
			RX_OPEN: begin
				ready = 1'b1;
			end
			RX_COIN: begin
				ready = 1'($urandom_range(0, 1));
			end
			RX_HOLD: begin
				if (rx_hold_left > 0) begin
					rx_hold_left--;
					ready = 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					rx_hold_left = $urandom_range(5, 30);
					ready = 1'b0;
				end else begin
					ready = 1'b1;
				end
			end
			default: begin
				ready = (rx_phase < 2);
			end
		endcase
		m_tready <= ready;
	end

	// Ends the run when no transaction of any kind has happened for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("seven_segment_number_serial_framer_top: mismatch");
			$finish;
		end
	end

	// Offers one command, in bursts with random gaps between them.
	task automatic send_command(input logic cmd, input logic [15:0] number);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= number;
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Holds the sender off until every outstanding slot has been received.
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_brightness(input logic [2:0] level);
		cfg_valid <= 1'b1;
		cfg_data  <= level;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random command: mostly numbers in range, some saturating, some inits.
	task automatic send_random_command();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			send_command(CMD_INIT, 16'($urandom));
		end else if (pick < 8) begin
			send_command(CMD_SHOW, 16'($urandom_range(0, 9999)));
		end else if (pick == 8) begin
			send_command(CMD_SHOW, 16'($urandom_range(10000, 65535)));
		end else begin
			send_command(CMD_SHOW, 16'($urandom));
		end
	endtask

	initial begin
		int level;
		s_tvalid  <= 1'b0;
		s_tdata   <= 16'd0;
		s_tuser   <= CMD_INIT;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 3'd0;
		arst_n    <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset brightness, number extremes, saturation, all digits.
		send_command(CMD_INIT, 16'h0000);
		send_command(CMD_SHOW, 16'd0);
		send_command(CMD_SHOW, 16'd9999);
		send_command(CMD_SHOW, 16'd10000);
		send_command(CMD_SHOW, 16'hFFFF);
		send_command(CMD_SHOW, 16'd1234);
		send_command(CMD_SHOW, 16'd5678);
		send_command(CMD_SHOW, 16'd9012);
		send_command(CMD_SHOW, 16'd8);
		send_command(CMD_SHOW, 16'd70);
		send_command(CMD_SHOW, 16'd600);
		send_command(CMD_SHOW, 16'hAAAA);
		send_command(CMD_SHOW, 16'h5555);
		send_command(CMD_INIT, 16'hFFFF);
		settle();
		write_brightness(3'd0);
		send_command(CMD_INIT, 16'd0);
		send_command(CMD_SHOW, 16'd4321);
		settle();
		write_brightness(3'd5);
		send_command(CMD_INIT, 16'd9999);
		settle();
		write_brightness(3'd2);
		send_command(CMD_INIT, 16'd0);

		// Random phases, each under its own brightness and gap setting.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			if (phase == 0) begin
				level = 7;
			end else if (phase == 1) begin
				level = 0;
			end else begin
				level = $urandom_range(0, 7);
			end
			write_brightness(3'(level));
			tx_gap_max = (phase == 2) ? 0 : $urandom_range(1, 12);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 3 && k == PHASE_ITEMS / 2) begin
					settle();
				end
				send_random_command();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("seven_segment_number_serial_framer_top: match");
		end else begin
			$display("seven_segment_number_serial_framer_top: mismatch");
		end
		$finish;
	end

endmodule
